// ----- hw/rtl/date_difference_in_days_defines.svh -----
// Assertion macros for the date difference block.
// Used by the checker; expects clk and rst_n in the enclosing scope.
`ifndef DATE_DIFFERENCE_IN_DAYS_DEFINES_SVH
`define DATE_DIFFERENCE_IN_DAYS_DEFINES_SVH

// Same-cycle implication.
`define DDD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ddd: implication failed");

// Next-cycle implication.
`define DDD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ddd: next-cycle implication failed");

`endif

// ----- hw/rtl/ddd_pkg.sv -----
// Shared widths, constants, types and month table for the date difference block.
// No dependencies.
`default_nettype none

package ddd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    localparam int ORD_W   = 23;
    localparam int MDAY_W  = 9;

    // floor(q / 25) == (q * RECIP_25) >> RECIP_SHIFT for q < 7989
    localparam logic [17:0] RECIP_25    = 18'd167773;
    localparam int          RECIP_SHIFT = 22;

    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd13;
    localparam logic [MONTH_W-1:0] MONTH_MARCH = 4'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } ddd_stage_en_t;

    // Days in months before month m, common year; 13 means the whole year.
    function automatic logic [MDAY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [MDAY_W-1:0] r;
        case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            4'd13:   r = 9'd365;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ddd_ordinal.sv -----
// Three-stage ordinal day number of one date (days since year 0).
// Depends on ddd_pkg.
`default_nettype none

module ddd_ordinal (
    input  wire logic                          clk,
    input  wire ddd_pkg::ddd_stage_en_t        en,
    input  wire logic [ddd_pkg::DAY_W-1:0]     day,
    input  wire logic [ddd_pkg::MONTH_W-1:0]   month,
    input  wire logic [ddd_pkg::YEAR_W-1:0]    year,
    output logic      [ddd_pkg::ORD_W-1:0]     ordinal
);
    import ddd_pkg::*;

    // stage 1: reciprocal products and year scaling
    logic [YEAR_W:0]    y_p3, y_p99, y_p399;
    logic [12:0]        yq_next, a_val;
    logic [10:0]        b_val;
    logic [11:0]        c_next;
    logic [30:0]        pa_next;
    logic [28:0]        pb_next;
    logic [29:0]        pc_next;
    logic [ORD_W-1:0]   y365_next;
    logic [MONTH_W-1:0] m_next;

    logic [12:0]        yq_reg;
    logic [11:0]        c_reg;
    logic [30:0]        pa_reg;
    logic [28:0]        pb_reg;
    logic [29:0]        pc_reg;
    logic [ORD_W-1:0]   y365_reg;
    logic [MONTH_W-1:0] m_reg;
    logic [DAY_W-1:0]   d_reg;
    logic               y4_reg, y16_reg;

    always_comb
    begin
        y_p3      = {1'b0, year} + 15'd3;
        y_p99     = {1'b0, year} + 15'd99;
        y_p399    = {1'b0, year} + 15'd399;
        yq_next   = y_p3[YEAR_W:2];
        a_val     = y_p99[YEAR_W:2];
        b_val     = y_p399[YEAR_W:4];
        c_next    = year[YEAR_W-1:2];
        pa_next   = 31'(a_val) * 31'(RECIP_25);
        pb_next   = 29'(b_val) * 29'(RECIP_25);
        pc_next   = 30'(c_next) * 30'(RECIP_25);
        y365_next = ORD_W'(year) * 23'd365;
        m_next    = (month > MONTH_LAST) ? MONTH_LAST : month;
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            yq_reg   <= yq_next;
            c_reg    <= c_next;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            pc_reg   <= pc_next;
            y365_reg <= y365_next;
            m_reg    <= m_next;
            d_reg    <= day;
            y4_reg   <= (year[1:0] == 2'd0);
            y16_reg  <= (year[3:0] == 4'd0);
        end
    end

    // stage 2: leap count, leap flag, month offset
    logic [8:0]         qa;
    logic [6:0]         qb;
    logic [7:0]         qc;
    logic [11:0]        c25;
    logic               div100, leap;
    logic [12:0]        leaps;
    logic [ORD_W-1:0]   base_next, base_reg;
    logic [MDAY_W-1:0]  mpart_next, mpart_reg;

    always_comb
    begin
        qa         = pa_reg[30:RECIP_SHIFT];
        qb         = pb_reg[28:RECIP_SHIFT];
        qc         = pc_reg[29:RECIP_SHIFT];
        c25        = 12'(qc) * 12'd25;
        div100     = (c_reg == c25);
        leap       = y4_reg && (!div100 || y16_reg);
        leaps      = yq_reg - 13'(qa) + 13'(qb);
        base_next  = y365_reg + ORD_W'(leaps);
        mpart_next = days_before_month(m_reg)
                   + MDAY_W'(leap && (m_reg >= MONTH_MARCH))
                   + MDAY_W'(d_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            base_reg  <= base_next;
            mpart_reg <= mpart_next;
        end
    end

    // stage 3: final sum
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            ordinal <= base_reg + ORD_W'(mpart_reg);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ddd_compare.sv -----
// Output stage: ordinal difference, order check and saturation.
// Depends on ddd_pkg.
`default_nettype none

module ddd_compare (
    input  wire logic                        clk,
    input  wire ddd_pkg::ddd_stage_en_t      en,
    input  wire logic [ddd_pkg::ORD_W-1:0]   start_ord,
    input  wire logic [ddd_pkg::ORD_W-1:0]   end_ord,
    output logic      [ddd_pkg::COUNT_W-1:0] day_count,
    output logic                             start_after_end
);
    import ddd_pkg::*;

    logic [ORD_W-1:0]   diff;
    logic               after_next;
    logic [COUNT_W-1:0] count_next;

    always_comb
    begin
        diff       = end_ord - start_ord;
        after_next = (start_ord > end_ord);
        if (after_next)
            count_next = '0;
        else if (diff > ORD_W'(COUNT_MAX))
            count_next = COUNT_MAX;
        else
            count_next = diff[COUNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            day_count       <= count_next;
            start_after_end <= after_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/date_difference_in_days.sv -----
// Top level of the date difference block: four-stage pipeline with valid bits.
// Depends on ddd_pkg, ddd_ordinal, ddd_compare.
//
//  channel   handshake                  payload
//  date      date_valid / date_ready    start_day, start_month, start_year,
//                                       end_day, end_month, end_year
//  count     count_valid / count_ready  day_count, start_after_end
//
// One item per cycle is sustained while the output is not stalled.
// Stages: reciprocal multiplies, leap count and month offset, ordinal sum,
// compare and saturate (last stage is the output register).
// Reset clears the valid bits only. A stall holds each full stage; empty
// stages keep filling, so bubbles close up behind a stalled output.
`default_nettype none

module date_difference_in_days (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            date_valid,
    output logic                                 date_ready,
    input  wire logic [ddd_pkg::DAY_W-1:0]       start_day,
    input  wire logic [ddd_pkg::MONTH_W-1:0]     start_month,
    input  wire logic [ddd_pkg::YEAR_W-1:0]      start_year,
    input  wire logic [ddd_pkg::DAY_W-1:0]       end_day,
    input  wire logic [ddd_pkg::MONTH_W-1:0]     end_month,
    input  wire logic [ddd_pkg::YEAR_W-1:0]      end_year,
    output logic                                 count_valid,
    input  wire logic                            count_ready,
    output logic      [ddd_pkg::COUNT_W-1:0]     day_count,
    output logic                                 start_after_end
);
    import ddd_pkg::*;

    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    ddd_stage_en_t en;
    logic [ORD_W-1:0] start_ord, end_ord;

    always_comb
    begin
        en.s4 = !v4_reg || count_ready;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign date_ready  = en.s1;
    assign count_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en.s1) v1_reg <= date_valid;
            if (en.s2) v2_reg <= v1_reg;
            if (en.s3) v3_reg <= v2_reg;
            if (en.s4) v4_reg <= v3_reg;
        end
    end

    ddd_ordinal u_start (
        .clk     (clk),
        .en      (en),
        .day     (start_day),
        .month   (start_month),
        .year    (start_year),
        .ordinal (start_ord)
    );

    ddd_ordinal u_end (
        .clk     (clk),
        .en      (en),
        .day     (end_day),
        .month   (end_month),
        .year    (end_year),
        .ordinal (end_ord)
    );

    ddd_compare u_cmp (
        .clk             (clk),
        .en              (en),
        .start_ord       (start_ord),
        .end_ord         (end_ord),
        .day_count       (day_count),
        .start_after_end (start_after_end)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ddd_checker.sv -----
// Port-level checks for the date difference block, bound to the top level.
// Depends on ddd_pkg and date_difference_in_days_defines.svh.
`default_nettype none
`include "date_difference_in_days_defines.svh"

module ddd_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        date_ready,
    input wire logic                        count_valid,
    input wire logic                        count_ready,
    input wire logic [ddd_pkg::COUNT_W-1:0] day_count,
    input wire logic                        start_after_end
);
    import ddd_pkg::*;

    // reversed dates report a zero count
    `DDD_ASSERT_IMP(a_after_zero, count_valid && start_after_end, day_count == '0)

    // input back-pressure only when the output is full and stalled
    `DDD_ASSERT_IMP(a_ready_full, !date_ready, count_valid && !count_ready)

    // a stalled result holds
    `DDD_ASSERT_NXT(a_hold, count_valid && !count_ready,
        count_valid && $stable(day_count) && $stable(start_after_end))

endmodule

bind date_difference_in_days ddd_checker u_ddd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .date_ready      (date_ready),
    .count_valid     (count_valid),
    .count_ready     (count_ready),
    .day_count       (day_count),
    .start_after_end (start_after_end)
);

`default_nettype wire

// ----- bench/date_difference_in_days_test.sv -----
// Self-checking testbench for date_difference_in_days: queued date pairs, a predicted count
// per accepted pair, checked in order against the count channel.
// Depends on ddd_pkg and the date_difference_in_days RTL.
`default_nettype none

module date_difference_in_days_test;

    import ddd_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_PER_PHASE = 113;

    typedef struct packed {
        logic [DAY_W-1:0]   sd;
        logic [MONTH_W-1:0] sm;
        logic [YEAR_W-1:0]  sy;
        logic [DAY_W-1:0]   ed;
        logic [MONTH_W-1:0] em;
        logic [YEAR_W-1:0]  ey;
    } date_pair_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               late;
    } count_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               date_valid = 1'b0;
    logic               date_ready;
    logic [DAY_W-1:0]   start_day = '0;
    logic [MONTH_W-1:0] start_month = '0;
    logic [YEAR_W-1:0]  start_year = '0;
    logic [DAY_W-1:0]   end_day = '0;
    logic [MONTH_W-1:0] end_month = '0;
    logic [YEAR_W-1:0]  end_year = '0;
    logic               count_valid;
    logic               count_ready = 1'b0;
    logic [COUNT_W-1:0] day_count;
    logic               start_after_end;

    date_pair_t    pending_dates[$];
    count_result_t expected_counts[$];
    date_pair_t    next_dates;
    count_result_t oldest_count;

    logic date_accepted;
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    int   dates_queued = 0;
    int   counts_checked = 0;
    int   late_seen = 0;
    int   mismatches = 0;
    int   cycle_count = 0;

    date_difference_in_days DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .date_valid      (date_valid),
        .date_ready      (date_ready),
        .start_day       (start_day),
        .start_month     (start_month),
        .start_year      (start_year),
        .end_day         (end_day),
        .end_month       (end_month),
        .end_year        (end_year),
        .count_valid     (count_valid),
        .count_ready     (count_ready),
        .day_count       (day_count),
        .start_after_end (start_after_end)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ---- predictor ----

    function automatic bit is_leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_to_year(int unsigned y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    function automatic int unsigned month_offset(logic [MONTH_W-1:0] m, bit leap);
        int unsigned r;
        case (m)
            4'd2:    r = 31;
            4'd3:    r = 59;
            4'd4:    r = 90;
            4'd5:    r = 120;
            4'd6:    r = 151;
            4'd7:    r = 181;
            4'd8:    r = 212;
            4'd9:    r = 243;
            4'd10:   r = 273;
            4'd11:   r = 304;
            4'd12:   r = 334;
            4'd0,
            4'd1:    r = 0;
            default: r = 365;  // 13 and above: whole year
        endcase
        if (m >= MONTH_MARCH && leap)
            r = r + 1;
        return r;
    endfunction

    function automatic int unsigned day_ordinal(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                                logic [YEAR_W-1:0] y);
        int unsigned yy;
        yy = y;
        return days_to_year(yy) + month_offset(m, is_leap_year(yy)) + d;
    endfunction

    function automatic count_result_t predict_count(date_pair_t p);
        count_result_t r;
        int unsigned   s;
        int unsigned   e;
        s = day_ordinal(p.sd, p.sm, p.sy);
        e = day_ordinal(p.ed, p.em, p.ey);
        if (s > e)
        begin
            r.count = '0;
            r.late  = 1'b1;
        end
        else
        begin
            r.count = (e - s > COUNT_MAX) ? COUNT_MAX : COUNT_W'(e - s);
            r.late  = 1'b0;
        end
        return r;
    endfunction

    // ---- stimulus helpers ----

    task automatic push_dates(int sd, int sm, int sy, int ed, int em, int ey);
        date_pair_t p;
        p.sd = DAY_W'(sd);
        p.sm = MONTH_W'(sm);
        p.sy = YEAR_W'(sy);
        p.ed = DAY_W'(ed);
        p.em = MONTH_W'(em);
        p.ey = YEAR_W'(ey);
        pending_dates.push_back(p);
        dates_queued++;
    endtask

    task automatic push_random_dates();
        int kind;
        int sy;
        int ey;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            // raw bits: day 0, month 0 and 13..15, years past 9999
            push_dates($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        else if (kind < 55)
        begin
            sy = $urandom_range(0, 9999);
            ey = sy + $urandom_range(0, 2);
            if (ey > 9999)
                ey = 9999;
            if ($urandom_range(0, 3) == 0)
                push_dates($urandom_range(1, 31), $urandom_range(1, 12), ey,
                           $urandom_range(1, 31), $urandom_range(1, 12), sy);
            else
                push_dates($urandom_range(1, 31), $urandom_range(1, 12), sy,
                           $urandom_range(1, 31), $urandom_range(1, 12), ey);
        end
        else
        begin
            push_dates($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(0, 9999),
                       $urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(0, 9999));
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 counts_checked, what, got, want);
        mismatches++;
    endtask

    // ---- driver and receiver, both change on the falling edge ----

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            date_accepted <= 1'b0;
        else
            date_accepted <= date_valid && date_ready;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!date_valid || date_accepted)
            begin
                if (pending_dates.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    next_dates = pending_dates.pop_front();
                    start_day   <= next_dates.sd;
                    start_month <= next_dates.sm;
                    start_year  <= next_dates.sy;
                    end_day     <= next_dates.ed;
                    end_month   <= next_dates.em;
                    end_year    <= next_dates.ey;
                    date_valid  <= 1'b1;
                end
                else
                begin
                    date_valid <= 1'b0;
                end
            end
            count_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // ---- monitor ----

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (date_valid && date_ready)
                expected_counts.push_back(predict_count({start_day, start_month, start_year,
                                                         end_day, end_month, end_year}));
            if (count_valid && count_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    report_mismatch("unexpected item, day_count", day_count, 0);
                end
                else
                begin
                    oldest_count = expected_counts.pop_front();
                    if (day_count !== oldest_count.count)
                        report_mismatch("day_count", day_count, oldest_count.count);
                    if (start_after_end !== oldest_count.late)
                        report_mismatch("start_after_end", start_after_end, oldest_count.late);
                    if (oldest_count.late)
                        late_seen++;
                    counts_checked++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("date_difference_in_days regression: fail");
        $finish;
    end

    // ---- phases ----

    initial
    begin : sequencer
        int idle_by_phase[4];
        int stall_by_phase[4];
        idle_by_phase  = '{0, 70, 0, 32};
        stall_by_phase = '{0, 0, 70, 32};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        push_dates(1, 1, 2000, 1, 1, 2000);       // same date
        push_dates(31, 12, 1999, 1, 1, 2000);     // year boundary
        push_dates(28, 2, 2000, 1, 3, 2000);      // 400-year leap
        push_dates(28, 2, 1900, 1, 3, 1900);      // century, not leap
        push_dates(28, 2, 2024, 1, 3, 2024);
        push_dates(29, 2, 2023, 1, 3, 2023);      // day past month end
        push_dates(1, 1, 0, 31, 12, 9999);        // full range
        push_dates(31, 12, 9999, 1, 1, 0);        // start after end
        push_dates(2, 1, 2000, 1, 1, 2000);       // one day late
        push_dates(0, 1, 0, 0, 1, 0);             // day zero
        push_dates(31, 0, 0, 0, 0, 16383);        // month zero, largest year, saturates
        push_dates(0, 0, 0, 31, 15, 16383);       // max field values
        push_dates(31, 15, 16383, 0, 0, 0);
        push_dates(1, 13, 2000, 1, 1, 2001);      // month 13 == whole year
        push_dates(1, 14, 2001, 1, 1, 2002);
        push_dates(1, 15, 1999, 1, 13, 1999);
        push_dates(1, 3, 0, 1, 3, 1);             // year zero is leap
        push_dates(1, 1, 100, 1, 1, 101);
        push_dates(1, 1, 400, 1, 1, 401);
        push_dates(1, 1, 9999, 31, 12, 9999);
        push_dates(15, 6, 1970, 15, 6, 2038);
        push_dates(0, 0, 0, 0, 0, 0);
        push_dates(31, 15, 16383, 31, 15, 16383);
        push_dates(1, 1, 4899, 1, 1, 16383);      // just past saturation
        push_dates(1, 1, 4900, 1, 1, 16383);      // just below saturation

        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct    = idle_by_phase[phase];
            receiver_stall_pct = stall_by_phase[phase];
            repeat (RANDOM_PER_PHASE)
                push_random_dates();
            // sender holds off until the pipeline has fully drained
            while (counts_checked != dates_queued)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_counts.size() != 0)
            report_mismatch("items left unanswered", 0, expected_counts.size());

        $display("%0d date pairs checked over four handshake phases, %0d with start after end",
                 counts_checked, late_seen);
        $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
        if (mismatches == 0)
            $display("date_difference_in_days regression: pass");
        else
            $display("date_difference_in_days regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- date_difference_in_days.f -----
+incdir+hw/rtl
hw/rtl/ddd_pkg.sv
hw/rtl/ddd_ordinal.sv
hw/rtl/ddd_compare.sv
hw/rtl/date_difference_in_days.sv
hw/rtl/ddd_checker.sv
bench/date_difference_in_days_test.sv
